// ===== src/tlhas_pkg.sv =====
// shared types, constants and helpers for the two-link hip angle solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlhas_pkg;

    localparam int ANGLE_FRAC_BITS     = 4;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int DEG_BITS            = 24;
    localparam int TAB_LEN             = 24;
    localparam longint GAIN_Q30        = 64'd652032874;

    // datapath widths
    localparam int LEN_W   = 10;
    localparam int VEC_W   = 40;   // signed vector components, Q16 mm (their squares are Q32)
    localparam int ANG_W   = 36;   // degrees * 2^24, signed
    localparam int SQ_W    = 56;   // squared magnitudes, Q32

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_REACH = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [0:0] REG_THIGH = 1'b0;
    localparam logic [0:0] REG_SHIN  = 1'b1;

    typedef struct packed {
        logic signed [12:0] knee_deg;
        logic signed [15:0] foot_dx;
    } in_beat_t;

    typedef struct packed {
        logic signed [12:0] hip_deg;
        logic [1:0]         status;
    } out_beat_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] v;
        begin
            case (i)
                0: v = 36'sd754974720;  1: v = 36'sd445687602;
                2: v = 36'sd235489089;  3: v = 36'sd119537938;
                4: v = 36'sd60000934;   5: v = 36'sd30029717;
                6: v = 36'sd15018523;   7: v = 36'sd7509720;
                8: v = 36'sd3754917;    9: v = 36'sd1877466;
                10: v = 36'sd938734;    11: v = 36'sd469367;
                12: v = 36'sd234684;    13: v = 36'sd117342;
                14: v = 36'sd58671;     15: v = 36'sd29335;
                16: v = 36'sd14668;     17: v = 36'sd7334;
                18: v = 36'sd3667;      19: v = 36'sd1833;
                20: v = 36'sd917;       21: v = 36'sd458;
                22: v = 36'sd229;       23: v = 36'sd115;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/two_link_hip_angle_solver_core.sv =====
// a beat passes the rotation, square root, vectoring and rounding register stages
// throughput: one beat per cycle; the whole pipe advances when the output side
// holds no beat or can take data, so a stalled output stalls every cell
// three chains of cordic cells and one chain of square root cells do the work
// reset clears the valid bits of every stage and sets both lengths to 100 mm
// depends on tlhas_pkg, tlhas_rot_cell, tlhas_sqrt_cell
`timescale 1ns / 1ps
`default_nettype none

module two_link_hip_angle_solver_core
    import tlhas_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire in_beat_t    in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output out_beat_t        out_data,
    input  wire              cfg_we,
    input  wire [0:0]        cfg_index,
    input  wire [LEN_W-1:0]  cfg_data
);

    localparam int NS     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int SQB    = SQ_W / 2;
    localparam int SHR    = DEG_BITS - ANGLE_FRAC_BITS;
    // stages: 0 quad, 1 scale, rot 2..NS+1, then p/q, squares, compare, sqrt,
    // vectoring, sum, round
    localparam int S_ROT0 = 2;
    localparam int S_PQ   = S_ROT0 + NS;
    localparam int S_SQ   = S_PQ + 1;
    localparam int S_CMP  = S_SQ + 1;
    localparam int S_SQR  = S_CMP + 1;
    localparam int S_VEC  = S_SQR + SQB;
    localparam int S_SUM  = S_VEC + NS;
    localparam int S_RND  = S_SUM + 1;
    localparam int NST    = S_RND + 1;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int FULL    = 4 * QUARTER;

    logic [LEN_W-1:0] thigh_reg;
    logic [LEN_W-1:0] shin_reg;
    logic [NST-1:0]   vld_reg;
    logic             adv;

    // sideband carried along every stage
    typedef struct packed {
        logic                    kpos;
        logic [1:0]              qd;
        logic                    rz;
        logic [LEN_W-1:0]        a;
        logic [LEN_W-1:0]        b;
        logic signed [VEC_W-1:0] c;
        logic signed [VEC_W-1:0] p;
        logic signed [VEC_W-1:0] q;
        logic [1:0]              st;
    } side_t;

    side_t sd_reg [NST];
    side_t sd_next [NST];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thigh_reg <= LEN_W'(100);
            shin_reg  <= LEN_W'(100);
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_THIGH)
                thigh_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_SHIN)
                shin_reg <= cfg_data;
            if (adv)
                vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // stage 0: angle reduction into quadrant and remainder
    logic signed [13:0] r_w;
    logic [13:0]        rem_w;
    logic [13:0]        rem0_reg;
    always_comb
    begin
        r_w = 14'(in_data.knee_deg);
        if (r_w >= 14'(FULL))
            r_w = r_w - 14'(FULL);
        if (r_w < 0)
            r_w = r_w + 14'(FULL);
        sd_next[0]      = '0;
        sd_next[0].kpos = in_data.knee_deg > 0;
        sd_next[0].a    = thigh_reg;
        sd_next[0].b    = shin_reg;
        sd_next[0].c    = VEC_W'(in_data.foot_dx) <<< 12;
        rem_w           = r_w;
        sd_next[0].qd   = 2'd0;
        if (rem_w >= 14'(3 * QUARTER))
        begin
            sd_next[0].qd = 2'd3;
            rem_w = rem_w - 14'(3 * QUARTER);
        end
        else if (rem_w >= 14'(2 * QUARTER))
        begin
            sd_next[0].qd = 2'd2;
            rem_w = rem_w - 14'(2 * QUARTER);
        end
        else if (rem_w >= 14'(QUARTER))
        begin
            sd_next[0].qd = 2'd1;
            rem_w = rem_w - 14'(QUARTER);
        end
        sd_next[0].rz = rem_w == 0;
    end

    // stage 1: gain-scaled start vector
    logic [LEN_W+31:0]       gprod_w;
    logic signed [VEC_W-1:0] rx [NS+1];
    logic signed [VEC_W-1:0] ry [NS+1];
    logic signed [ANG_W-1:0] rzz [NS+1];
    logic signed [VEC_W-1:0] x0_reg;
    logic signed [ANG_W-1:0] z0_reg;

    assign gprod_w = (LEN_W+32)'(sd_reg[0].b) * (LEN_W+32)'(GAIN_Q30);
    always_comb
    begin
        sd_next[1] = sd_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem0_reg <= rem_w;
            x0_reg   <= VEC_W'(gprod_w[LEN_W+31:14]);
            z0_reg   <= ANG_W'(rem0_reg) <<< SHR;
        end
    end

    assign rx[0]  = x0_reg;
    assign ry[0]  = '0;
    assign rzz[0] = z0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_rot
            tlhas_rot_cell #(.STEP(gi), .VECTORING(1'b0)) u_cell (
                .clk (clk), .en (adv),
                .x (rx[gi]), .y (ry[gi]), .z (rzz[gi]),
                .x_q (rx[gi+1]), .y_q (ry[gi+1]), .z_q (rzz[gi+1])
            );
        end
        for (gi = 2; gi < NST; gi++)
        begin : g_side
            if (gi != S_PQ && gi != S_SQ && gi != S_CMP)
            begin : g_pass
                always_comb
                begin
                    sd_next[gi] = sd_reg[gi-1];
                end
            end
        end
        for (gi = 0; gi < NST; gi++)
        begin : g_sreg
            always_ff @(posedge clk)
            begin
                if (adv)
                    sd_reg[gi] <= sd_next[gi];
            end
        end
    endgenerate

    // p/q with quadrant fix-up
    logic signed [VEC_W-1:0] bc_w, bs_w, bq;
    always_comb
    begin
        bq = VEC_W'(sd_reg[S_PQ-1].b) <<< 16;
        bc_w = sd_reg[S_PQ-1].rz ? bq : rx[NS];
        bs_w = sd_reg[S_PQ-1].rz ? '0 : ry[NS];
        sd_next[S_PQ] = sd_reg[S_PQ-1];
        case (sd_reg[S_PQ-1].qd)
            2'd1:
            begin
                sd_next[S_PQ].p = -bs_w;
                sd_next[S_PQ].q = bc_w;
            end
            2'd2:
            begin
                sd_next[S_PQ].p = -bc_w;
                sd_next[S_PQ].q = -bs_w;
            end
            2'd3:
            begin
                sd_next[S_PQ].p = bs_w;
                sd_next[S_PQ].q = -bc_w;
            end
            default:
            begin
                sd_next[S_PQ].p = bc_w;
                sd_next[S_PQ].q = bs_w;
            end
        endcase
        sd_next[S_PQ].p = sd_next[S_PQ].p + (VEC_W'(sd_reg[S_PQ-1].a) <<< 16);
    end

    // squares, one multiplier each, registered
    logic [SQ_W-1:0] pp_reg, qq_reg, cc_reg;
    logic [SQ_W-1:0] pp_w, qq_w, cc_w;
    logic [27:0]     pa_w, qa_w, ca_w;
    always_comb
    begin
        sd_next[S_SQ] = sd_reg[S_SQ-1];
        pa_w = 28'(sd_reg[S_SQ-1].p < 0 ? -sd_reg[S_SQ-1].p : sd_reg[S_SQ-1].p);
        qa_w = 28'(sd_reg[S_SQ-1].q < 0 ? -sd_reg[S_SQ-1].q : sd_reg[S_SQ-1].q);
        ca_w = 28'(sd_reg[S_SQ-1].c < 0 ? -sd_reg[S_SQ-1].c : sd_reg[S_SQ-1].c);
        pp_w = SQ_W'(pa_w) * SQ_W'(pa_w);
        qq_w = SQ_W'(qa_w) * SQ_W'(qa_w);
        cc_w = SQ_W'(ca_w) * SQ_W'(ca_w);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg <= pp_w;
            qq_reg <= qq_w;
            cc_reg <= cc_w;
        end
    end

    // compare and radicand
    logic [SQ_W-1:0] d2_w;
    logic [SQ_W-1:0] sq_rem [SQB+1];
    logic [SQ_W-1:0] sq_root [SQB+1];
    logic [SQ_W-1:0] rad_reg;
    always_comb
    begin
        d2_w = pp_reg + qq_reg;
        sd_next[S_CMP] = sd_reg[S_CMP-1];
        if (d2_w == 0)
            sd_next[S_CMP].st = ST_ZERO;
        else if (cc_reg > d2_w)
            sd_next[S_CMP].st = ST_REACH;
        else
            sd_next[S_CMP].st = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rad_reg <= pp_reg + qq_reg - cc_reg;
    end

    assign sq_rem[0]  = rad_reg;
    assign sq_root[0] = '0;

    generate
        for (gi = 0; gi < SQB; gi++)
        begin : g_sqrt
            tlhas_sqrt_cell #(.BITPOS(SQB - 1 - gi)) u_cell (
                .clk (clk), .en (adv),
                .rem (sq_rem[gi]), .root (sq_root[gi]),
                .rem_q (sq_rem[gi+1]), .root_q (sq_root[gi+1])
            );
        end
    endgenerate

    // two vectoring chains side by side
    logic signed [VEC_W-1:0] ax [NS+1];
    logic signed [VEC_W-1:0] ay [NS+1];
    logic signed [ANG_W-1:0] az [NS+1];
    logic signed [VEC_W-1:0] bx [NS+1];
    logic signed [VEC_W-1:0] by [NS+1];
    logic signed [ANG_W-1:0] bz [NS+1];
    side_t sv;
    assign sv    = sd_reg[S_VEC-1];
    assign ax[0] = sv.p < 0 ? -sv.p : sv.p;
    assign ay[0] = sv.q;
    assign az[0] = '0;
    assign bx[0] = sv.c < 0 ? -sv.c : sv.c;
    assign by[0] = VEC_W'(sq_root[SQB]);
    assign bz[0] = '0;

    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_vec
            tlhas_rot_cell #(.STEP(gi), .VECTORING(1'b1)) u_a (
                .clk (clk), .en (adv),
                .x (ax[gi]), .y (ay[gi]), .z (az[gi]),
                .x_q (ax[gi+1]), .y_q (ay[gi+1]), .z_q (az[gi+1])
            );
            tlhas_rot_cell #(.STEP(gi), .VECTORING(1'b1)) u_b (
                .clk (clk), .en (adv),
                .x (bx[gi]), .y (by[gi]), .z (bz[gi]),
                .x_q (bx[gi+1]), .y_q (by[gi+1]), .z_q (bz[gi+1])
            );
        end
    endgenerate

    // sum, negate for a positive knee, round and saturate; fault beats give zero
    logic signed [ANG_W-1:0] hip_reg;
    logic signed [ANG_W-1:0] ang2_w, hsum_w, hr_w;
    logic signed [12:0]      hsat_w;
    out_beat_t               out_reg;
    always_comb
    begin
        ang2_w = (sd_reg[S_SUM-1].c < 0) ? (ANG_W'(180) <<< DEG_BITS) - bz[NS] : bz[NS];
        hsum_w = az[NS] + ang2_w - (ANG_W'(90) <<< DEG_BITS);
        if (sd_reg[S_SUM-1].kpos)
            hsum_w = -hsum_w;
        hr_w = (hip_reg + (ANG_W'(1) <<< (SHR - 1))) >>> SHR;
        if (hr_w > 4095)
            hsat_w = 13'sd4095;
        else if (hr_w < -4096)
            hsat_w = 13'sh1000;
        else
            hsat_w = 13'(hr_w);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hip_reg         <= hsum_w;
            out_reg.status  <= sd_reg[S_RND-1].st;
            out_reg.hip_deg <= (sd_reg[S_RND-1].st == ST_OK) ? hsat_w : 13'sd0;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status != 2'd3))
        else $error("bad status code");
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.hip_deg == 13'sd0)
        else $error("fault beat carries nonzero hip angle");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/tlhas_rot_cell.sv =====
// one cordic micro-rotation cell, rotation or vectoring mode, with one register stage
// depends on tlhas_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlhas_rot_cell
    import tlhas_pkg::*;
#(
    parameter int STEP = 0,
    parameter bit VECTORING = 1'b0
)(
    input  wire                     clk,
    input  wire                     en,
    input  wire signed [VEC_W-1:0]  x,
    input  wire signed [VEC_W-1:0]  y,
    input  wire signed [ANG_W-1:0]  z,
    output logic signed [VEC_W-1:0] x_q,
    output logic signed [VEC_W-1:0] y_q,
    output logic signed [ANG_W-1:0] z_q
);

    logic                    dir;
    logic signed [VEC_W-1:0] x_next;
    logic signed [VEC_W-1:0] y_next;
    logic signed [ANG_W-1:0] z_next;
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    // arithmetic shift floors, as the algorithm needs
    always_comb
    begin
        dir = VECTORING ? (y >= 0) : (z < 0);
        if (!dir)
        begin
            x_next = x - (y >>> STEP);
            y_next = y + (x >>> STEP);
            z_next = VECTORING ? z - atan_deg(STEP) : z - atan_deg(STEP);
        end
        else
        begin
            x_next = x + (y >>> STEP);
            y_next = y - (x >>> STEP);
            z_next = z + atan_deg(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_q = x_reg;
    assign y_q = y_reg;
    assign z_q = z_reg;

endmodule

`default_nettype wire

// ===== src/tlhas_sqrt_cell.sv =====
// one restoring square root cell: settles one result bit, one register stage
// depends on tlhas_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlhas_sqrt_cell
    import tlhas_pkg::*;
#(
    parameter int BITPOS = 0
)(
    input  wire              clk,
    input  wire              en,
    input  wire [SQ_W-1:0]   rem,
    input  wire [SQ_W-1:0]   root,
    output logic [SQ_W-1:0]  rem_q,
    output logic [SQ_W-1:0]  root_q
);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_W-1:0] root_next;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] root_reg;

    // root holds the partial result; trial = (2*root + 2^bit) * 2^bit
    always_comb
    begin
        trial = (root << (BITPOS + 1)) + (SQ_W'(1) << (2 * BITPOS));
        if (rem >= trial)
        begin
            rem_next  = rem - trial;
            root_next = root | (SQ_W'(1) << BITPOS);
        end
        else
        begin
            rem_next  = rem;
            root_next = root;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_q  = rem_reg;
    assign root_q = root_reg;

endmodule

`default_nettype wire

// ===== tb/two_link_hip_angle_solver_core_test.sv =====
// self-checking testbench for two_link_hip_angle_solver_core: random and directed beats,
// fixed-point hip angle prediction, random idling on both sides, one long output hold-off
// depends on tlhas_pkg and the core
`timescale 1ns / 1ps

module two_link_hip_angle_solver_core_test;
    import tlhas_pkg::*;

    typedef longint unsigned u64_t;

    localparam int LATENCY   = 7 + 2 * CORDIC_STEPS_DEF + 28;
    localparam int MAX_CYCLES = 400000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_THIGH;
    logic [LEN_W-1:0] cfg_data = '0;

    in_beat_t pending_beats[$];
    out_beat_t expected_hips[$];
    logic [LEN_W-1:0] thigh_mm = 10'd100;
    logic [LEN_W-1:0] shin_mm = 10'd100;
    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_go = 1'b0;
    bit hold_off = 1'b0;
    int hold_count = 0;
    logic in_taken = 1'b0;

    two_link_hip_angle_solver_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115};
        return tab[i];
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_step(i);
            end
            else
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic out_beat_t solve_hip(in_beat_t beat);
        longint k, off, a, b, r, rem, bc, bs, t, p, q, c, hip, x, y, z, nx, h, ang1, ang2;
        longint unsigned d2, c2;
        int qd;
        out_beat_t res;
        k = beat.knee_deg;
        off = beat.foot_dx;
        a = longint'(thigh_mm) <<< 16;
        b = longint'(shin_mm) <<< 16;
        hip = 0;
        res.status = ST_OK;
        r = k % 5760;
        if (r < 0)
            r += 5760;
        qd = int'(r / 1440);
        rem = r % 1440;
        if (rem == 0)
        begin
            bc = b;
            bs = 0;
        end
        else
        begin
            x = longint'((u64_t'(b) * u64_t'(GAIN_Q30)) >> 30);
            y = 0;
            z = rem <<< 20;
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shift(y, i);
                    y = y + floor_shift(x, i);
                    z -= atan_step(i);
                end
                else
                begin
                    nx = x + floor_shift(y, i);
                    y = y - floor_shift(x, i);
                    z += atan_step(i);
                end
                x = nx;
            end
            bc = x;
            bs = y;
        end
        if (qd == 1)
        begin
            t = bc; bc = -bs; bs = t;
        end
        else if (qd == 2)
        begin
            bc = -bc; bs = -bs;
        end
        else if (qd == 3)
        begin
            t = bc; bc = bs; bs = -t;
        end
        p = a + bc;
        q = bs;
        d2 = u64_t'(p * p) + u64_t'(q * q);
        c = off * 4096;
        c2 = u64_t'(c * c);
        if (d2 == 0)
            res.status = ST_ZERO;
        else if (c2 > d2)
            res.status = ST_REACH;
        else
        begin
            h = longint'(floor_sqrt(d2 - c2));
            ang1 = vector_angle(p < 0 ? -p : p, q);
            if (c >= 0)
                ang2 = vector_angle(c, h);
            else
                ang2 = (longint'(180) <<< 24) - vector_angle(-c, h);
            hip = ang1 + ang2 - (longint'(90) <<< 24);
            if (k > 0)
                hip = -hip;
            hip = floor_shift(hip + (longint'(1) <<< 19), 20);
            if (hip > 4095)
                hip = 4095;
            if (hip < -4096)
                hip = -4096;
        end
        res.hip_deg = hip[12:0];
        return res;
    endfunction

    // driver: new beat offered at the falling edge after acceptance
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 27))
            begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= calm || $urandom_range(99) >= 27;
    end

    // receiver hold-off, counted in cycles once requested
    always @(posedge clk)
    begin
        if (hold_go && hold_count < HOLD_CYCLES)
        begin
            hold_off <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            hold_off <= 1'b0;
    end

    // monitor: predict on accepted input beat, check on accepted output beat
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_hips.push_back(solve_hip(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hips.size() == 0)
            begin
                $error("unexpected output beat hip_deg=%0d status=%0d",
                    out_data.hip_deg, out_data.status);
                errors++;
            end
            else
            begin
                out_beat_t want;
                want = expected_hips.pop_front();
                if (out_data.hip_deg !== want.hip_deg)
                begin
                    $error("hip_deg expected %0d actual %0d", want.hip_deg,
                        out_data.hip_deg);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    errors++;
                end
            end
        end
        if (cycles > MAX_CYCLES)
        begin
            $display("two_link_hip_angle_solver_core regression: fail");
            $finish;
        end
    end

    task automatic add_beat(int knee, int off);
        in_beat_t b;
        b.knee_deg = knee[12:0];
        b.foot_dx = off[15:0];
        pending_beats.push_back(b);
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_hips.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_lengths(int thigh, int shin);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_THIGH;
        cfg_data <= thigh[LEN_W-1:0];
        @(negedge clk);
        cfg_index <= REG_SHIN;
        cfg_data <= shin[LEN_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        thigh_mm = thigh[LEN_W-1:0];
        shin_mm = shin[LEN_W-1:0];
    endtask

    task automatic random_beats(int n);
        int knee;
        int off;
        int reach;
        for (int i = 0; i < n; i++)
        begin
            reach = (thigh_mm + shin_mm) * 16;
            knee = $urandom_range(99) < 80 ? $urandom_range(5760) - 2880
                : $urandom_range(8191) - 4096;
            if ($urandom_range(99) < 75)
                off = $urandom_range(2 * reach) - reach;
            else
                off = $urandom_range(65535) - 32768;
            if (off > 32767)
                off = 32767;
            if (off < -32768)
                off = -32768;
            add_beat(knee, off);
        end
    endtask

    initial
    begin
        int settings[5][2];
        settings = '{'{1, 1}, '{1023, 1023}, '{1023, 1}, '{1, 1023}, '{200, 350}};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, quadrant edges, straight leg, reach limits
        add_beat(0, 0);
        add_beat(2880, 0);
        add_beat(-2880, 0);
        add_beat(1440, 0);
        add_beat(-1440, 0);
        add_beat(4095, 32767);
        add_beat(-4096, -32768);
        add_beat(0, 3200);
        add_beat(0, -3200);
        add_beat(2880, 1);
        add_beat(2879, 5);
        add_beat(-2879, -5);
        add_beat(5, 3199);
        add_beat(720, -1000);
        add_beat(-720, 1000);
        add_beat(100, 32767);
        add_beat(-100, -32768);
        add_beat(1, 0);
        add_beat(-1, 0);
        add_beat(2000, 2000);
        drain();

        write_lengths(100, 100);
        random_beats(300);
        // long receiver hold-off while the sender keeps offering
        hold_go = 1'b1;
        calm = 1'b1;
        random_beats(150);
        drain();
        calm = 1'b0;

        foreach (settings[s])
        begin
            write_lengths(settings[s][0], settings[s][1]);
            add_beat(2880, 0);
            add_beat(0, 32767);
            random_beats(160);
            drain();
        end

        if (errors == 0)
            $display("two_link_hip_angle_solver_core regression: pass");
        else
            $display("two_link_hip_angle_solver_core regression: fail");
        $finish;
    end
endmodule
